/* hw/rtl/csb_pkg.sv */
// Shared types and constants of the cross stencil blur.
// Used by csb_cross and cross_stencil_blur; depends on nothing.
package csb_pkg;

    localparam int CSB_LINE_MAX  = 512;
    localparam int CHAN_W        = 10;
    localparam int WID_W         = 10;
    localparam int HGT_W         = 13;
    localparam int ROW_W         = 12;
    localparam int CFG_DATA_W    = 13;
    localparam int TDATA_W       = 32;
    localparam int HEIGHT_MAX    = 4096;
    localparam int FRAME_MIN     = 3;
    localparam int W_CENTER      = 133;
    localparam int W_EDGE        = 31;
    localparam int ROUND_HALF    = 128;
    localparam int SAMPLE_MAX    = 1023;

    localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(480);
    localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(360);

    typedef logic [CHAN_W-1:0] t_chan;
    // index 0 red, 1 green, 2 blue; red in the lowest bits
    typedef t_chan [2:0] t_pix;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

endpackage

/* hw/rtl/cross_stencil_blur.sv */
// Cross stencil blur: five-point cross filter over a raster RGB stream.
// An accepted item is held in the input stage registers and then in the output register.
// Throughput: one item per cycle unless stalled, set by each buffer's single read port.
// Reset: synchronous, active low; clears counters and valid flags, loads width 480
// and height 360. Line buffers are not cleared.
// Depends on csb_pkg, csb_ram and csb_cross.
module cross_stencil_blur #(
    parameter int LINE_MAX = csb_pkg::CSB_LINE_MAX
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [csb_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [csb_pkg::TDATA_W-1:0]    s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                           s_axis_tuser,  // operation
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [csb_pkg::TDATA_W-1:0]    m_axis_tdata,  // red_out, green_out, blue_out
    output logic                           m_axis_tlast   // frame_last
);
    import csb_pkg::*;

    localparam int AW    = $clog2(LINE_MAX);
    localparam int EW    = $clog2(LINE_MAX + 1);
    localparam int PW    = $clog2(LINE_MAX + 2);
    localparam int CW    = (EW > WID_W) ? EW : WID_W;
    localparam int PIX_W = 3 * CHAN_W;

    logic [WID_W-1:0] r_frame_width;
    logic [HGT_W-1:0] r_frame_height;
    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [PW-1:0]    r_pend;
    logic [AW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;
    logic [PW-1:0]    n_pend;

    logic [EW-1:0]    eff_w;
    logic [HGT_W-1:0] eff_h;
    logic [AW-1:0]    col_cur;
    logic [ROW_W-1:0] row_cur;
    logic [EW-1:0]    col_p1;
    logic [HGT_W-1:0] row_p1;
    logic [PW-1:0]    pend_full;
    logic [PW-1:0]    drain_k_m1;
    logic             pend_ok;
    logic             is_drain;
    logic             in_acc;
    logic             s1_go;

    logic             r_s1_valid;
    logic             r_s1_out;
    logic             r_s1_filt;
    logic             r_s1_pixel;
    logic             r_s1_from_ram;
    logic             r_s1_last;
    logic [AW-1:0]    r_s1_col;
    t_pix             r_s1_pix;
    logic             n_s1_out;
    logic             n_s1_filt;
    logic             n_s1_from_ram;
    logic             n_s1_last;

    t_pix             r_win0;
    t_pix             r_win1;
    t_pix             r_win2;
    t_pix             r_prev;
    t_pix             older_q;
    t_pix             newer_q;
    t_pix             cross_pix;
    t_pix             result;
    logic [AW-1:0]    newer_raddr;

    logic             r_out_valid;
    logic             r_out_last;
    t_pix             r_out_pix;

    always_comb begin
        priority if (CW'(r_frame_width) > CW'(LINE_MAX)) begin
            eff_w = EW'(LINE_MAX);
        end else if (r_frame_width < WID_W'(FRAME_MIN)) begin
            eff_w = EW'(FRAME_MIN);
        end else begin
            eff_w = EW'(r_frame_width);
        end
        priority if (r_frame_height > HGT_W'(HEIGHT_MAX)) begin
            eff_h = HGT_W'(HEIGHT_MAX);
        end else if (r_frame_height < HGT_W'(FRAME_MIN)) begin
            eff_h = HGT_W'(FRAME_MIN);
        end else begin
            eff_h = r_frame_height;
        end
    end

    assign col_cur    = (EW'(r_col) >= eff_w) ? '0 : r_col;
    assign row_cur    = (HGT_W'(r_row) >= eff_h) ? '0 : r_row;
    assign col_p1     = EW'(col_cur) + EW'(1);
    assign row_p1     = HGT_W'(row_cur) + HGT_W'(1);
    assign pend_full  = PW'(eff_w) + PW'(1);
    assign drain_k_m1 = PW'(eff_w) - r_pend;
    assign pend_ok    = (r_pend != '0) && (r_pend <= pend_full);
    assign is_drain   = (t_op'(s_axis_tuser) == OP_DRAIN);

    assign s1_go         = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_go;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_col         = r_col;
        n_row         = r_row;
        n_pend        = '0;
        n_s1_out      = 1'b0;
        n_s1_filt     = 1'b0;
        n_s1_from_ram = 1'b0;
        n_s1_last     = 1'b0;
        if (is_drain) begin
            if (pend_ok) begin
                n_s1_out      = 1'b1;
                n_s1_from_ram = (r_pend != pend_full);
                n_s1_last     = (r_pend == PW'(1));
                n_pend        = r_pend - PW'(1);
            end
        end else begin
            n_s1_out  = ((col_cur != '0) && (row_cur != '0))
                     || ((col_cur == '0) && (row_cur >= ROW_W'(2)));
            n_s1_filt = (col_cur >= AW'(2)) && (row_cur >= ROW_W'(2));
            if (col_p1 >= eff_w) begin
                n_col = '0;
                if (row_p1 >= eff_h) begin
                    n_row  = '0;
                    n_pend = pend_full;
                end else begin
                    n_row = row_p1[ROW_W-1:0];
                end
            end else begin
                n_col = col_p1[AW-1:0];
                n_row = row_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RST;
            r_frame_height <= HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
            r_pend         <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[WID_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[HGT_W-1:0];
                default:          r_frame_width  <= r_frame_width;
            endcase
            r_col  <= '0;
            r_row  <= '0;
            r_pend <= '0;
        end else if (in_acc) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_out      <= n_s1_out;
            r_s1_filt     <= n_s1_filt;
            r_s1_pixel    <= !is_drain;
            r_s1_from_ram <= n_s1_from_ram;
            r_s1_last     <= n_s1_last;
            r_s1_col      <= col_cur;
            r_s1_pix      <= s_axis_tdata[PIX_W-1:0];
        end
    end

    assign newer_raddr = is_drain ? drain_k_m1[AW-1:0] : col_cur;

    csb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LINE_MAX)
    ) u_older_row (
        .i_clk   (i_clk),
        .i_we    (s1_go && r_s1_pixel),
        .i_waddr (r_s1_col),
        .i_wdata (newer_q),
        .i_re    (in_acc),
        .i_raddr (col_cur),
        .o_rdata (older_q)
    );

    csb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LINE_MAX)
    ) u_newer_row (
        .i_clk   (i_clk),
        .i_we    (s1_go && r_s1_pixel),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_pix),
        .i_re    (in_acc),
        .i_raddr (newer_raddr),
        .o_rdata (newer_q)
    );

    csb_cross u_cross (
        .i_ctr   (r_win1),
        .i_left  (r_win0),
        .i_right (newer_q),
        .i_up    (r_win2),
        .i_down  (r_prev),
        .o_pix   (cross_pix)
    );

    always_comb begin
        priority if (r_s1_filt) begin
            result = cross_pix;
        end else if (r_s1_from_ram) begin
            result = newer_q;
        end else begin
            result = r_win1;
        end
    end

    // advance the window on every pixel item
    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_pixel) begin
            r_win0 <= r_win1;
            r_win1 <= newer_q;
            r_win2 <= older_q;
            r_prev <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= r_s1_out;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_pix  <= result;
            r_out_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out_pix);
    assign m_axis_tlast  = r_out_last;

endmodule

/* hw/rtl/csb_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module csb_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/csb_cross.sv */
// Five-point cross filter over three channels, rounded and saturated.
// Depends on csb_pkg.
module csb_cross (
    input  csb_pkg::t_pix i_ctr,
    input  csb_pkg::t_pix i_left,
    input  csb_pkg::t_pix i_right,
    input  csb_pkg::t_pix i_up,
    input  csb_pkg::t_pix i_down,
    output csb_pkg::t_pix o_pix
);
    import csb_pkg::*;

    localparam int SUM_W = CHAN_W + 2;
    localparam int ACC_W = CHAN_W + 9;

    for (genvar k = 0; k < 3; k++) begin : g_chan
        logic [SUM_W-1:0]    edge_sum;
        logic [ACC_W-1:0]    acc;
        logic [ACC_W-9:0]    scaled;

        assign edge_sum = SUM_W'(i_left[k]) + SUM_W'(i_right[k])
                        + SUM_W'(i_up[k]) + SUM_W'(i_down[k]);
        assign acc = ACC_W'(W_CENTER) * ACC_W'(i_ctr[k])
                   + ACC_W'(W_EDGE) * ACC_W'(edge_sum)
                   + ACC_W'(ROUND_HALF);
        assign scaled = acc[ACC_W-1:8];
        assign o_pix[k] = (scaled > (ACC_W-8)'(SAMPLE_MAX)) ? CHAN_W'(SAMPLE_MAX)
                                                            : scaled[CHAN_W-1:0];
    end

endmodule
